FILE: hdl/gdrc_pkg.sv
// ----------------------------------------------------------------------------
// gdrc_pkg
// shared constants, types and state codes of the grid dda column raycaster
// ----------------------------------------------------------------------------
package gdrc_pkg;

  localparam int unsigned SCREEN_W      = 512;
  localparam int unsigned SCREEN_H      = 256;
  localparam int unsigned MAP_SIZE      = 32;
  localparam int unsigned MAX_STEPS_DEF = 64;

  localparam int unsigned LINE_SAT  = 1024;
  // perp at or below this gives a line height of LINE_SAT or more
  localparam int unsigned PERP_SAT  = SCREEN_H * (65536 / LINE_SAT);

  localparam int unsigned MAP_DEPTH = 1024;
  localparam int unsigned MAP_AW    = 10;
  localparam int unsigned TILE_W    = 8;

  localparam int unsigned QUOT_W    = 31;   // quotient / dividend width
  localparam int unsigned DIST_W    = 38;   // side and perpendicular distances

  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 21;

  // register indexes of the configuration port
  localparam logic [CFG_AW-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_AW-1:0] REG_PLANE_Y = 3'd5;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RAY,
    S_SETUP,
    S_DIV_X,
    S_DIV_Y,
    S_SIDE,
    S_STEP,
    S_TEST,
    S_HEIGHT,
    S_SPAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic              start;
    logic [QUOT_W-1:0] dividend;
    logic [DIST_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] addr;
    logic [TILE_W-1:0] data;
  } map_wr_t;

endpackage

FILE: hdl/grid_dda_column_raycaster_core.sv
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster_core
// fixed-point dda raycaster over a 32 x 32 tile map, one column per cast request
// ----------------------------------------------------------------------------
// cast: forms the ray, checks the camera, runs up to two divisions on the shared
//   divider and initialises the side distances; each map step then reads the map
//   and then tests the tile; a hit adds the line height division (none when saturated)
// one request at a time; a write request only writes the map memory
// reset: the map memory is cleared after reset, during which
//   no request is taken; camera registers load their reset values at once
module grid_dda_column_raycaster_core
  import gdrc_pkg::*;
#(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input requests
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // column, cell_x, cell_y, cell_value
  input  logic [0:0]        s_axis_tuser,   // func
  // results
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata,   // out_column, draw_start, draw_end,
                                            // hit_side, wall_value
  output logic [0:0]        m_axis_tuser,   // hit
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_AW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned STEP_W = $clog2(MAX_STEPS + 1);
  localparam logic signed [6:0] MAP_LIM = 7'(MAP_SIZE);

  state_e state_q, state_d;

  // camera registers
  logic [20:0]        pos_x_q, pos_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  // request capture
  logic [8:0]          col_q;
  logic signed [17:0]  rdx_q, rdy_q;
  logic [QUOT_W-1:0]   dlt_x_q, dlt_y_q;
  logic [DIST_W-1:0]   sd_x_q, sd_y_q, perp_q;
  logic signed [6:0]   mx_q, my_q;
  logic [STEP_W-1:0]   step_q;
  logic                side_q, hit_q, div_pend_q;
  logic [TILE_W-1:0]   wall_q;
  logic [10:0]         lh_q;
  logic [7:0]          start_q, end_q;

  // output register
  logic        m_valid_q;
  logic [39:0] m_data_q;
  logic        m_hit_q;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  map_wr_t           map_wr;
  logic [MAP_AW-1:0] rd_addr;
  logic [TILE_W-1:0] rd_data;
  logic              map_ready;

  logic in_acc, out_free;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // ray forming: camera_x in q.14 from the clamped column
  logic [8:0]         col_c;
  logic [23:0]        col_scaled;
  logic signed [15:0] camx;
  logic signed [31:0] prod_x, prod_y;
  logic signed [17:0] rx_c, ry_c;

  assign col_c      = (32'(col_q) >= SCREEN_W) ? 9'(SCREEN_W - 1) : col_q;
  assign col_scaled = 24'((32'(col_c) * 32768) / SCREEN_W);
  assign camx       = 16'(signed'({1'b0, col_scaled}) - 25'sd16384);
  assign prod_x     = plane_x_q * camx;
  assign prod_y     = plane_y_q * camx;

  // divide by 16384 rounding toward zero
  function automatic logic signed [17:0] q14_trunc(input logic signed [31:0] p);
    logic signed [31:0] adj;
    adj = p[31] ? p + 32'sd16383 : p;
    return 18'(adj >>> 14);
  endfunction

  assign rx_c = 18'(dir_x_q) + q14_trunc(prod_x);
  assign ry_c = 18'(dir_y_q) + q14_trunc(prod_y);

  // per-axis magnitudes and start fractions
  logic [16:0] abs_x, abs_y, fx, fy;
  assign abs_x = 17'(rdx_q[17] ? -rdx_q : rdx_q);
  assign abs_y = 17'(rdy_q[17] ? -rdy_q : rdy_q);
  assign fx    = rdx_q[17] ? {1'b0, pos_x_q[15:0]} : 17'd65536 - {1'b0, pos_x_q[15:0]};
  assign fy    = rdy_q[17] ? {1'b0, pos_y_q[15:0]} : 17'd65536 - {1'b0, pos_y_q[15:0]};

  logic [47:0] sprod_x, sprod_y;
  assign sprod_x = 48'(fx) * 48'(dlt_x_q);
  assign sprod_y = 48'(fy) * 48'(dlt_y_q);

  // one dda step; ties step y
  logic              take_x, off_map;
  logic signed [6:0] nmx, nmy;
  assign take_x  = sd_x_q < sd_y_q;
  assign nmx     = take_x ? (rdx_q[17] ? mx_q - 7'sd1 : mx_q + 7'sd1) : mx_q;
  assign nmy     = take_x ? my_q : (rdy_q[17] ? my_q - 7'sd1 : my_q + 7'sd1);
  assign off_map = nmx < 0 || nmx >= MAP_LIM || nmy < 0 || nmy >= MAP_LIM;
  assign rd_addr = {nmx[4:0], nmy[4:0]};

  // span from line height
  logic [10:0] half_lh;
  assign half_lh = lh_q >> 1;

  gdrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  gdrc_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (map_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .ready_o   (map_ready)
  );

  assign map_wr.we   = in_acc && (s_axis_tuser[0] == FUNC_WRITE);
  assign map_wr.addr = {s_axis_tdata[13:9], s_axis_tdata[18:14]};
  assign map_wr.data = s_axis_tdata[26:19];

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d          = state_q;
    s_axis_tready    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = QUOT_W'(32'h4000_0000);
    div_req.divisor  = '0;
    unique case (state_q)
      S_CLEAR: begin
        if (map_ready) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc && s_axis_tuser[0] == FUNC_CAST) state_d = S_RAY;
      end
      S_RAY: state_d = S_SETUP;
      S_SETUP: begin
        // both components zero or camera outside the map: miss at once
        if ((rdx_q == 0 && rdy_q == 0) || mx_q >= MAP_LIM || my_q >= MAP_LIM) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_DIV_X;
        end
      end
      S_DIV_X: begin
        div_req.divisor = DIST_W'(abs_x);
        if (rdx_q == 0) begin
          state_d = S_DIV_Y;
        end else if (!div_pend_q) begin
          div_req.start = 1'b1;
        end else if (div_rsp.done) begin
          state_d = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        div_req.divisor = DIST_W'(abs_y);
        if (rdy_q == 0) begin
          state_d = S_SIDE;
        end else if (!div_pend_q) begin
          div_req.start = 1'b1;
        end else if (div_rsp.done) begin
          state_d = S_SIDE;
        end
      end
      S_SIDE: state_d = S_STEP;
      S_STEP: state_d = off_map ? S_FINISH : S_TEST;
      S_TEST: begin
        if (rd_data != '0) begin
          state_d = S_HEIGHT;
        end else if (step_q == STEP_W'(MAX_STEPS)) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_STEP;
        end
      end
      S_HEIGHT: begin
        div_req.dividend = QUOT_W'(SCREEN_H * 65536);
        div_req.divisor  = perp_q;
        if (perp_q <= DIST_W'(PERP_SAT)) begin
          state_d = S_SPAN;
        end else if (!div_pend_q) begin
          div_req.start = 1'b1;
        end else if (div_rsp.done) begin
          state_d = S_SPAN;
        end
      end
      S_SPAN: state_d = S_FINISH;
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------ camera registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= 21'd1081344;
      pos_y_q   <= 21'd1081344;
      dir_x_q   <= -16'sd16384;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= 16'sd10813;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_POS_X:   pos_x_q   <= cfg_data_i;
        REG_POS_Y:   pos_y_q   <= cfg_data_i;
        REG_DIR_X:   dir_x_q   <= cfg_data_i[15:0];
        REG_DIR_Y:   dir_y_q   <= cfg_data_i[15:0];
        REG_PLANE_X: plane_x_q <= cfg_data_i[15:0];
        REG_PLANE_Y: plane_y_q <= cfg_data_i[15:0];
        default: ;   // indexes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------- control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pend_q <= 1'b0;
      step_q     <= '0;
      hit_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (div_req.start) begin
        div_pend_q <= 1'b1;
      end else if (div_rsp.done) begin
        div_pend_q <= 1'b0;
      end
      if (in_acc) begin
        step_q <= '0;
        hit_q  <= 1'b0;
      end else if (state_q == S_STEP) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == S_TEST && rd_data != '0) hit_q <= 1'b1;
      if (state_q == S_FINISH && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        col_q <= s_axis_tdata[8:0];
        mx_q  <= {2'b00, pos_x_q[20:16]};
        my_q  <= {2'b00, pos_y_q[20:16]};
      end
      S_RAY: begin
        rdx_q <= rx_c;
        rdy_q <= ry_c;
      end
      S_DIV_X: begin
        if (rdx_q == 0) dlt_x_q <= '0;
        else if (div_rsp.done) dlt_x_q <= div_rsp.quot;
      end
      S_DIV_Y: begin
        if (rdy_q == 0) dlt_y_q <= '0;
        else if (div_rsp.done) dlt_y_q <= div_rsp.quot;
      end
      S_SIDE: begin
        // a zero component never steps: park its side distance above any reach
        sd_x_q <= (rdx_q == 0) ? '1 : DIST_W'(sprod_x[47:16]);
        sd_y_q <= (rdy_q == 0) ? '1 : DIST_W'(sprod_y[47:16]);
      end
      S_STEP: begin
        mx_q   <= nmx;
        my_q   <= nmy;
        side_q <= !take_x;
        if (take_x) sd_x_q <= sd_x_q + DIST_W'(dlt_x_q);
        else        sd_y_q <= sd_y_q + DIST_W'(dlt_y_q);
      end
      S_TEST: begin
        wall_q <= rd_data;
        perp_q <= side_q ? sd_y_q - DIST_W'(dlt_y_q) : sd_x_q - DIST_W'(dlt_x_q);
      end
      S_HEIGHT: begin
        if (perp_q <= DIST_W'(PERP_SAT)) lh_q <= 11'(LINE_SAT);
        else if (div_rsp.done) lh_q <= div_rsp.quot[10:0];
      end
      S_SPAN: begin
        start_q <= (half_lh >= 11'(SCREEN_H / 2)) ? 8'd0
                                                  : 8'(11'(SCREEN_H / 2) - half_lh);
        end_q   <= (half_lh + 11'(SCREEN_H / 2) >= 11'(SCREEN_H - 1)) ?
                   8'(SCREEN_H - 1) : 8'(half_lh + 11'(SCREEN_H / 2));
      end
      default: ;
    endcase
    if (state_q == S_FINISH && out_free) begin
      m_data_q <= {6'd0,
                   hit_q ? wall_q  : 8'd0,
                   hit_q && side_q,
                   hit_q ? end_q   : 8'd0,
                   hit_q ? start_q : 8'd0,
                   col_q};
      m_hit_q  <= hit_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_hit_q;

  // ------------------------------------------------------------- assertions
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(step_q) <= MAX_STEPS)
    else $error("step count beyond limit");

  a_read_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TEST |-> (mx_q >= 0 && mx_q < MAP_LIM && my_q >= 0 && my_q < MAP_LIM))
    else $error("map read outside the map");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && m_valid_q && !m_axis_tready) |=> state_q == S_FINISH)
    else $error("result dropped while output stalled");

endmodule

FILE: hdl/gdrc_div.sv
// ----------------------------------------------------------------------------
// gdrc_div
// restoring divider, one quotient bit per cycle, shared by all divisions
// ----------------------------------------------------------------------------
module gdrc_div
  import gdrc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, done_q;
  logic [4:0]        cnt_q;
  logic [DIST_W-1:0] rem_q, dvs_q;
  logic [QUOT_W-1:0] quot_q;
  logic [DIST_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, quot_q[QUOT_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QUOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
      quot_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q  <= fits ? DIST_W'(trial - {1'b0, dvs_q}) : trial[DIST_W-1:0];
      quot_q <= {quot_q[QUOT_W-2:0], fits};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

FILE: hdl/gdrc_map.sv
// ----------------------------------------------------------------------------
// gdrc_map
// tile map memory with a clearing pass after reset, registered read
// ----------------------------------------------------------------------------
module gdrc_map
  import gdrc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  map_wr_t           wr_i,
  input  logic [MAP_AW-1:0] rd_addr_i,
  output logic [TILE_W-1:0] rd_data_o,
  output logic              ready_o
);

  logic [TILE_W-1:0] mem [MAP_DEPTH];
  logic [MAP_AW:0]   clr_q;
  logic [TILE_W-1:0] rd_data_q;
  logic              clearing;

  assign clearing = !clr_q[MAP_AW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem[clr_q[MAP_AW-1:0]] <= '0;
    end else if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clearing;

endmodule
